FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

FILE: rtl/tmbba_pkg.sv
// Package for the two-master burst bus arbiter: sizes, codes and item types.
// Depends on nothing; the engine, the top level and the checker refer to it by scoped names.
`default_nettype none

package tmbba_pkg;

	localparam int NUM_MASTERS = 2;
	localparam int PTR_W       = (NUM_MASTERS > 1) ? $clog2(NUM_MASTERS) : 1;
	// One finish for the running burst, then a grant and a finish per master.
	localparam int MAX_RESULTS = 1 + 2 * NUM_MASTERS;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic {
		REQ_MASTER    = 1'b0,
		REQ_WORD_DONE = 1'b1
	} req_kind_t;

	typedef enum logic {
		EV_GRANT  = 1'b0,
		EV_FINISH = 1'b1
	} event_kind_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic        requester;
		logic [31:0] address;
		logic        operation;
		logic [7:0]  burst_length;
	} req_t;

	typedef struct packed {
		event_kind_t event_kind;
		logic        granted_master;
		logic [31:0] grant_address;
		logic        grant_operation;
		logic [7:0]  grant_length;
		logic        last;
	} res_t;

	typedef res_t [MAX_RESULTS-1:0] res_vec_t;

	typedef struct packed {
		logic [31:0] address;
		logic        operation;
		logic [7:0]  length;
	} slot_t;

endpackage

`default_nettype wire

FILE: rtl/tmbba_engine.sv
// Arbitration engine: pending slots, bus owner, burst counter, rotating pointer.
// Depends on tmbba_pkg. Computes all results of one item combinationally.
`default_nettype none

module tmbba_engine (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    fire,
	input  wire tmbba_pkg::req_t         item,
	output tmbba_pkg::res_vec_t          res_vec,
	output logic [tmbba_pkg::CNT_W-1:0]  res_cnt
);

	localparam int N  = tmbba_pkg::NUM_MASTERS;
	localparam int PW = tmbba_pkg::PTR_W;
	localparam int CW = tmbba_pkg::CNT_W;

	logic [N-1:0]     slot_valid_q, slot_valid_d;
	tmbba_pkg::slot_t slot_q [N];
	tmbba_pkg::slot_t slot_d [N];
	tmbba_pkg::slot_t cur_q, cur_d;
	logic             busy_q, busy_d;
	logic [PW-1:0]    owner_q, owner_d;
	logic [7:0]       words_q, words_d;
	logic [PW-1:0]    ptr_q, ptr_d;

	always_comb begin
		logic [PW:0]   cand;
		logic [PW-1:0] win;
		logic          found;
		logic [CW-1:0] n;
		tmbba_pkg::res_vec_t vec;

		slot_valid_d = slot_valid_q;
		slot_d       = slot_q;
		cur_d        = cur_q;
		busy_d       = busy_q;
		owner_d      = owner_q;
		words_d      = words_q;
		ptr_d        = ptr_q;
		vec          = '0;
		n            = '0;
		win          = '0;
		found        = 1'b0;
		cand         = '0;

		if (fire) begin
			if (item.req_type == tmbba_pkg::REQ_MASTER) begin
				// A request into a full slot is dropped without a trace.
				if (int'(item.requester) < N && !slot_valid_d[PW'(item.requester)]) begin
					slot_valid_d[PW'(item.requester)] = 1'b1;
					slot_d[PW'(item.requester)] = '{address: item.address,
						operation: item.operation, length: item.burst_length};
				end
			end else if (busy_d) begin
				if (words_d != 8'd0) begin
					words_d = words_d - 8'd1;
				end
				if (words_d == 8'd0) begin
					vec[n] = '{tmbba_pkg::EV_FINISH, 1'(owner_d), cur_d.address,
						cur_d.operation, cur_d.length, 1'b0};
					n = n + 1'b1;
					busy_d = 1'b0;
					ptr_d = (ptr_d == PW'(N - 1)) ? '0 : ptr_d + 1'b1;
				end
			end

			// Each grant empties a slot, so N attempts cover every chain of
			// zero-length bursts.
			for (int g = 0; g < N; g++) begin
				if (!busy_d) begin
					found = 1'b0;
					win   = '0;
					for (int i = 0; i < N; i++) begin
						cand = {1'b0, ptr_d} + (PW + 1)'(i);
						if (cand >= (PW + 1)'(N)) begin
							cand = cand - (PW + 1)'(N);
						end
						if (!found && slot_valid_d[cand[PW-1:0]]) begin
							found = 1'b1;
							win   = cand[PW-1:0];
						end
					end
					if (found) begin
						owner_d           = win;
						cur_d             = slot_d[win];
						slot_valid_d[win] = 1'b0;
						busy_d            = 1'b1;
						words_d           = cur_d.length;
						vec[n] = '{tmbba_pkg::EV_GRANT, 1'(owner_d), cur_d.address,
							cur_d.operation, cur_d.length, 1'b0};
						n = n + 1'b1;
						if (words_d == 8'd0) begin
							vec[n] = '{tmbba_pkg::EV_FINISH, 1'(owner_d), cur_d.address,
								cur_d.operation, cur_d.length, 1'b0};
							n = n + 1'b1;
							busy_d = 1'b0;
							ptr_d = (ptr_d == PW'(N - 1)) ? '0 : ptr_d + 1'b1;
						end
					end
				end
			end

			if (n != '0) begin
				vec[n - 1'b1].last = 1'b1;
			end
		end

		res_vec = vec;
		res_cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			busy_q       <= 1'b0;
			owner_q      <= '0;
			words_q      <= '0;
			ptr_q        <= '0;
		end else begin
			slot_valid_q <= slot_valid_d;
			busy_q       <= busy_d;
			owner_q      <= owner_d;
			words_q      <= words_d;
			ptr_q        <= ptr_d;
		end
	end

	// Slot and burst payloads are only read while marked valid or busy.
	always_ff @(posedge clk) begin
		slot_q <= slot_d;
		cur_q  <= cur_d;
	end

endmodule

`default_nettype wire

FILE: rtl/two_master_burst_bus_arbiter_unit.sv
// An item waits in the input register stage, then its results go to the result buffer.
// One item per cycle while out_ready is high and each item causes at most one result;
// with more results, the input is held until the last result leaves the one output port.
// Reset (arst_n low, asynchronous): all pending slots empty, bus idle, pointer at master 0.
// No clearing pass follows reset; slot payloads are written before they are ever read.
// Depends on tmbba_pkg and tmbba_engine.
`default_nettype none

module two_master_burst_bus_arbiter_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire tmbba_pkg::req_t in_item,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output tmbba_pkg::res_t      out_item
);

	localparam int R  = tmbba_pkg::MAX_RESULTS;
	localparam int CW = tmbba_pkg::CNT_W;

	// Input register stage. It decouples the input handshake from the
	// arbitration logic so that ready depends only on the input stage, the result buffer and out_ready.
	logic            valid_s1;
	tmbba_pkg::req_t item_s1;

	// Result buffer: the results of one item as a shift line. Entry 0 is
	// what the output port shows; remaining count says how many are live.
	tmbba_pkg::res_vec_t batch_s2;
	logic [CW-1:0]       rem_s2;

	tmbba_pkg::res_vec_t eng_vec;
	logic [CW-1:0]       eng_cnt;
	logic                batch_free;
	logic                fire;
	logic                out_take;

	assign out_valid = (rem_s2 != '0);
	assign out_item  = batch_s2[0];
	assign out_take  = out_valid && out_ready;

	// The buffer can take a new batch when it is empty or its final item
	// leaves in this cycle. The staged item is processed exactly then.
	assign batch_free = (rem_s2 == '0) || (rem_s2 == CW'(1) && out_ready);
	assign fire       = valid_s1 && batch_free;
	assign in_ready   = !valid_s1 || batch_free;

	tmbba_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.res_vec (eng_vec),
		.res_cnt (eng_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rem_s2   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				rem_s2 <= eng_cnt;
			end else if (out_take) begin
				rem_s2 <= rem_s2 - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
		if (fire) begin
			batch_s2 <= eng_vec;
		end else if (out_take) begin
			for (int i = 0; i < R - 1; i++) begin
				batch_s2[i] <= batch_s2[i + 1];
			end
			batch_s2[R - 1] <= '0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tmbba_checker.sv
// Port-level checker for the burst bus arbiter, bound to the top level.
// Depends on tmbba_pkg, assert_macros.svh and two_master_burst_bus_arbiter_unit.
`default_nettype none
`include "assert_macros.svh"

module tmbba_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire tmbba_pkg::res_t out_item
);

	logic take;
	logic stall;
	logic grant;
	logic zero_grant;
	logic data_grant;

	assign take       = out_valid && out_ready;
	assign stall      = out_valid && !out_ready;
	assign grant      = out_valid && out_item.event_kind == tmbba_pkg::EV_GRANT;
	assign zero_grant = grant && out_item.grant_length == 8'd0;
	assign data_grant = grant && out_item.grant_length != 8'd0;

	// A stalled result holds still.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, stall, out_valid && $stable(out_item))
	// Results of one item leave back to back: a non-final result always has a successor.
	`ASSERT_NEXT(a_batch_cont, clk, arst_n, take && !out_item.last, out_valid)
	// A zero-length grant is always followed by its own finish.
	`ASSERT_SAME(a_zero_not_last, clk, arst_n, zero_grant, !out_item.last)
	// A burst with words makes the bus busy, so nothing else follows its grant.
	`ASSERT_SAME(a_busy_grant_last, clk, arst_n, data_grant, out_item.last)
	// With no result waiting the block always takes a new item.
	`ASSERT_SAME(a_empty_ready, clk, arst_n, !out_valid, in_ready)

endmodule

bind two_master_burst_bus_arbiter_unit tmbba_checker u_tmbba_checker (.*);

`default_nettype wire
